// ===== rtl/tmld_pkg.sv =====
// Shared types and constants for the tile map layer deframer.
`default_nettype none

package tmld_pkg;

   // Header is two little-endian 16-bit values: width, then height.
   localparam int unsigned HEADER_BYTES = 4;
   // Number of extended layers after the base layer.
   localparam logic [2:0] EXT_LAYERS = 3'd4;

   // Result queue depth and derived widths.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Result kinds.
   localparam logic KIND_WORD   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // End of file status codes.
   localparam logic [2:0] STATUS_OK_BASE    = 3'd0;
   localparam logic [2:0] STATUS_OK_FULL    = 3'd1;
   localparam logic [2:0] STATUS_SMALL      = 3'd2;
   localparam logic [2:0] STATUS_ZERO_DIM   = 3'd3;
   localparam logic [2:0] STATUS_BASE_SHORT = 3'd4;
   localparam logic [2:0] STATUS_EXT_SHORT  = 3'd5;
   localparam logic [2:0] STATUS_TRAILING   = 3'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic        item_kind;
      logic [2:0]  layer_id;
      logic [33:0] word_index;
      logic [15:0] word_value;
      logic [2:0]  status_code;
      logic [15:0] map_width;
      logic [15:0] map_height;
      logic        last_of_run;
   } rsp_type;

   // Results produced by one request; the first slot is always filled first.
   typedef struct packed {
      logic first_valid;
      logic second_valid;
   } push_type;

endpackage

`default_nettype wire

// ===== rtl/tmld_parser.sv =====
// Byte parser: header, base layer and extended layer framing, result generation.
`default_nettype none

module tmld_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire tmld_pkg::req_type req,
   output tmld_pkg::push_type     push,
   output tmld_pkg::rsp_type      rsp_first,
   output tmld_pkg::rsp_type      rsp_second
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_BASE,
      PH_BASE_DONE,
      PH_EXT,
      PH_FULL_DONE,
      PH_ABSORB
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  header_count_ff, header_count_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] tile_total_ff, tile_total_in;
   logic [33:0] word_counter_ff, word_counter_in;
   logic [2:0]  layer_ff, layer_in;
   logic [7:0]  low_byte_ff, low_byte_in;
   logic        odd_ff, odd_in;
   logic [2:0]  error_ff, error_in;

   logic [33:0] count_next;
   logic [33:0] layer_limit;
   logic [15:0] word;
   logic [2:0]  status;
   logic        word_done;
   tmld_pkg::rsp_type word_rsp;
   tmld_pkg::rsp_type status_rsp;

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      width_in        = width_ff;
      height_in       = height_ff;
      tile_total_in   = tile_total_ff;
      word_counter_in = word_counter_ff;
      layer_in        = layer_ff;
      low_byte_in     = low_byte_ff;
      odd_in          = odd_ff;
      error_in        = error_ff;
      word_done       = 1'b0;
      word            = {req.data_byte, low_byte_ff};
      status          = tmld_pkg::STATUS_OK_BASE;

      // The first byte after a complete base layer opens layer one.
      if (phase_in == PH_BASE_DONE) begin
         phase_in        = PH_EXT;
         layer_in        = 3'd1;
         word_counter_in = '0;
         odd_in          = 1'b0;
      end

      count_next  = word_counter_in + 34'd1;
      layer_limit = (layer_in == 3'd0) ? {2'b00, tile_total_in} : {tile_total_in, 2'b00};

      case (phase_in)
         PH_HEADER: begin
            case (header_count_ff)
               3'd0: width_in = {8'h00, req.data_byte};
               3'd1: width_in[15:8] = req.data_byte;
               3'd2: height_in = {8'h00, req.data_byte};
               default: height_in[15:8] = req.data_byte;
            endcase
            header_count_in = header_count_ff + 3'd1;
            if (header_count_in >= 3'(tmld_pkg::HEADER_BYTES)) begin
               if (width_in == 16'd0 || height_in == 16'd0) begin
                  error_in = tmld_pkg::STATUS_ZERO_DIM;
                  phase_in = PH_ABSORB;
               end else begin
                  tile_total_in   = {16'h0000, width_in} * {16'h0000, height_in};
                  phase_in        = PH_BASE;
                  layer_in        = 3'd0;
                  word_counter_in = '0;
                  odd_in          = 1'b0;
               end
            end
         end
         PH_BASE, PH_EXT: begin
            if (!odd_in) begin
               low_byte_in = req.data_byte;
               odd_in      = 1'b1;
            end else begin
               word_done = 1'b1;
               odd_in    = 1'b0;
               if (count_next >= layer_limit) begin
                  word_counter_in = '0;
                  if (phase_in == PH_BASE) begin
                     phase_in = PH_BASE_DONE;
                  end else if (layer_in >= tmld_pkg::EXT_LAYERS) begin
                     phase_in = PH_FULL_DONE;
                  end else begin
                     layer_in = layer_in + 3'd1;
                  end
               end else begin
                  word_counter_in = count_next;
               end
            end
         end
         PH_FULL_DONE: begin
            error_in = tmld_pkg::STATUS_TRAILING;
            phase_in = PH_ABSORB;
         end
         default: begin
         end
      endcase

      case (phase_in)
         PH_HEADER:    status = tmld_pkg::STATUS_SMALL;
         PH_BASE:      status = tmld_pkg::STATUS_BASE_SHORT;
         PH_BASE_DONE: status = tmld_pkg::STATUS_OK_BASE;
         PH_EXT:       status = tmld_pkg::STATUS_EXT_SHORT;
         PH_FULL_DONE: status = tmld_pkg::STATUS_OK_FULL;
         default:      status = error_ff == error_in ? error_ff : error_in;
      endcase
   end

   // Word results carry the layer and index held before this byte advanced them.
   always_comb begin
      word_rsp.item_kind   = tmld_pkg::KIND_WORD;
      word_rsp.layer_id    = (phase_ff == PH_BASE_DONE) ? 3'd1 : layer_ff;
      word_rsp.word_index  = (phase_ff == PH_BASE_DONE) ? 34'd0 : word_counter_ff;
      word_rsp.word_value  = word;
      word_rsp.status_code = tmld_pkg::STATUS_OK_BASE;
      word_rsp.map_width   = width_in;
      word_rsp.map_height  = height_in;
      word_rsp.last_of_run = !req.final_byte;

      status_rsp.item_kind   = tmld_pkg::KIND_STATUS;
      status_rsp.layer_id    = 3'd0;
      status_rsp.word_index  = 34'd0;
      status_rsp.word_value  = 16'd0;
      status_rsp.status_code = status;
      status_rsp.map_width   = width_in;
      status_rsp.map_height  = height_in;
      status_rsp.last_of_run = 1'b1;

      push.first_valid  = accept && (word_done || req.final_byte);
      push.second_valid = accept && word_done && req.final_byte;
      rsp_first         = word_done ? word_rsp : status_rsp;
      rsp_second        = status_rsp;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req.final_byte)) begin
         phase_ff        <= PH_HEADER;
         header_count_ff <= '0;
         width_ff        <= '0;
         height_ff       <= '0;
         tile_total_ff   <= '0;
         word_counter_ff <= '0;
         layer_ff        <= '0;
         low_byte_ff     <= '0;
         odd_ff          <= 1'b0;
         error_ff        <= tmld_pkg::STATUS_OK_BASE;
      end else if (accept) begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         width_ff        <= width_in;
         height_ff       <= height_in;
         tile_total_ff   <= tile_total_in;
         word_counter_ff <= word_counter_in;
         layer_ff        <= layer_in;
         low_byte_ff     <= low_byte_in;
         odd_ff          <= odd_in;
         error_ff        <= error_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tmld_result_queue.sv =====
// Small result queue that takes up to two results per cycle and delivers one.
`default_nettype none

module tmld_result_queue (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire tmld_pkg::push_type                   push,
   input  wire tmld_pkg::rsp_type                    rsp_first,
   input  wire tmld_pkg::rsp_type                    rsp_second,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output tmld_pkg::rsp_type                         rsp_data,
   output logic [tmld_pkg::QUEUE_CNT_W-1:0]          fill
);

   localparam int unsigned PW = tmld_pkg::QUEUE_PTR_W;
   localparam int unsigned CW = tmld_pkg::QUEUE_CNT_W;

   tmld_pkg::rsp_type entry_ff [tmld_pkg::QUEUE_DEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW-1:0] wr_next;
   logic [1:0]    push_n;
   logic          pop;

   always_comb begin
      pop       = rsp_valid && !rsp_stall;
      push_n    = {1'b0, push.first_valid} + {1'b0, push.second_valid};
      wr_next   = wr_ptr_ff + PW'(1);
      wr_ptr_in = wr_ptr_ff + PW'(push_n);
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      count_in  = count_ff + CW'(push_n) - CW'(pop);
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign fill      = count_ff;

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[wr_ptr_ff] <= rsp_first;
      end
      if (push.second_valid) begin
         entry_ff[wr_next] <= rsp_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tile_map_layer_deframer_unit.sv =====
// A result is queued when its request is accepted, and offered after earlier results.
// Throughput: one request per cycle while req_stall is low; a final byte completing
// a word yields two results, delivered one per cycle from the four-entry result queue
// while rsp_stall is low. Stall is raised while the queue holds more than two results.
// Reset (synchronous) returns the parser to the header phase and empties the queue.
`default_nettype none

module tile_map_layer_deframer_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tmld_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tmld_pkg::rsp_type      rsp_data
);

   tmld_pkg::push_type                 push;
   tmld_pkg::rsp_type                  rsp_first;
   tmld_pkg::rsp_type                  rsp_second;
   logic [tmld_pkg::QUEUE_CNT_W-1:0]   fill;
   logic                               req_accept;

   // Keep room for the two results one request can cause.
   assign req_stall  = (fill > tmld_pkg::QUEUE_CNT_W'(tmld_pkg::QUEUE_DEPTH - 2));
   assign req_accept = req_valid && !req_stall;

   tmld_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .req        (req_data),
      .push       (push),
      .rsp_first  (rsp_first),
      .rsp_second (rsp_second)
   );

   tmld_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .rsp_first  (rsp_first),
      .rsp_second (rsp_second),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fill       (fill)
   );

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      fill <= tmld_pkg::QUEUE_CNT_W'(tmld_pkg::QUEUE_DEPTH))
      else $error("result queue overfilled");

   a_final_gives_result : assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.final_byte |=> rsp_valid)
      else $error("final byte produced no result");

   a_push_order : assert property (@(posedge clock) disable iff (reset)
      push.second_valid |-> push.first_valid && req_accept)
      else $error("second result pushed without first");

   a_status_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.item_kind == tmld_pkg::KIND_STATUS |-> rsp_data.last_of_run)
      else $error("status result not marked last");

endmodule

`default_nettype wire
